// ===== rtl/montgomery_multiply_core_defines.svh =====
// Assertion macros shared by the Montgomery multiplier RTL.
`ifndef MONTGOMERY_MULTIPLY_CORE_DEFINES_SVH
`define MONTGOMERY_MULTIPLY_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MMC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mmc_pkg.sv =====
// Shared types and constants of the Montgomery multiplier.
`default_nettype none

package mmc_pkg;

   // Pipeline depth: valid bit index of each stage
   localparam int NUM_STAGES    = 8;
   localparam int ST_AB_PP      = 0;
   localparam int ST_AB_SUM     = 1;
   localparam int ST_Q_PP       = 2;
   localparam int ST_Q_SUM      = 3;
   localparam int ST_QM_PP      = 4;
   localparam int ST_QM_SUM     = 5;
   localparam int ST_ADD        = 6;
   localparam int ST_REDUCE     = 7;

   // Register indexes on the configuration port
   localparam logic [0:0] REG_MODULUS     = 1'b0;
   localparam logic [0:0] REG_NEG_INVERSE = 1'b1;

   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 4;

   // Register reset values
   localparam logic [CSR_DATA_BITS-1:0] MODULUS_RESET     = 64'd1;
   localparam logic [CSR_DATA_BITS-1:0] NEG_INVERSE_RESET = '1;

   // Load enables of the two stages of one pipelined multiplier
   typedef struct packed {
      logic pp_en;
      logic sum_en;
   } mul_en_type;

endpackage

`default_nettype wire

// ===== rtl/mmc_wide_mul.sv =====
// Two-stage pipelined word by word multiplier built from four half-word products.
`default_nettype none

module mmc_wide_mul
   import mmc_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  wire logic                     clock,
   input  wire mul_en_type               en,
   input  wire logic [WORD_BITS-1:0]     mul_a,
   input  wire logic [WORD_BITS-1:0]     mul_b,
   output logic      [2*WORD_BITS-1:0]   mul_prod
);

   localparam int HALF = (WORD_BITS + 1) / 2;
   localparam int PAD  = 2 * HALF;
   localparam int FULL = 4 * HALF;

   logic [PAD-1:0] a_pad, b_pad;
   logic [HALF-1:0] a_lo, a_hi, b_lo, b_hi;
   logic [PAD-1:0] pp00_in, pp01_in, pp10_in, pp11_in;
   logic [PAD-1:0] pp00_ff, pp01_ff, pp10_ff, pp11_ff;
   logic [FULL-1:0] sum_in;
   logic [2*WORD_BITS-1:0] prod_ff;

   // split operands into half words
   assign a_pad = PAD'(mul_a);
   assign b_pad = PAD'(mul_b);
   assign a_lo  = a_pad[HALF-1:0];
   assign a_hi  = a_pad[PAD-1:HALF];
   assign b_lo  = b_pad[HALF-1:0];
   assign b_hi  = b_pad[PAD-1:HALF];

   // partial products
   assign pp00_in = PAD'(a_lo) * PAD'(b_lo);
   assign pp01_in = PAD'(a_lo) * PAD'(b_hi);
   assign pp10_in = PAD'(a_hi) * PAD'(b_lo);
   assign pp11_in = PAD'(a_hi) * PAD'(b_hi);

   always_ff @(posedge clock) begin
      if (en.pp_en) begin
         pp00_ff <= pp00_in;
         pp01_ff <= pp01_in;
         pp10_ff <= pp10_in;
         pp11_ff <= pp11_in;
      end
   end

   // align and add the partial products
   assign sum_in = FULL'(pp00_ff)
                 + ((FULL'(pp01_ff) + FULL'(pp10_ff)) << HALF)
                 + (FULL'(pp11_ff) << PAD);

   always_ff @(posedge clock) begin
      if (en.sum_en) begin
         prod_ff <= sum_in[2*WORD_BITS-1:0];
      end
   end

   assign mul_prod = prod_ff;

endmodule

`default_nettype wire

// ===== rtl/montgomery_multiply_core.sv =====
// Top level of the pipelined Montgomery multiplier with REDC and its register port.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------
//  request   | req_valid/ready    | req_operand_a, req_operand_b
//  response  | rsp_valid/ready    | rsp_product
//  registers | psel/penable/...   | modulus (addr 0), neg_inverse (addr 8)
//
// One transaction enters per cycle while the output is not stalled; the
// pipeline holds three two-stage multipliers (a*b, low(t)*neg_inverse, q*modulus),
// the double-width add and the final conditional subtraction.
// Reset clears all stage valid bits and loads the registers with their defaults.
// A stall holds each occupied stage up to the first empty one; empty stages keep filling behind it.
`default_nettype none
`include "montgomery_multiply_core_defines.svh"

module montgomery_multiply_core
   import mmc_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [63:0]              req_operand_a,
   input  wire logic [63:0]              req_operand_b,
   // response channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic      [63:0]              rsp_product,
   // register port
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   localparam int W = WORD_BITS;

   logic [CSR_DATA_BITS-1:0] modulus_ff, neg_inverse_ff;
   logic [W-1:0] mod_w, ninv_w;
   logic [0:0] csr_index;
   logic csr_write;

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES:0] rdy;

   mul_en_type ab_en, q_en, qm_en;
   logic [2*W-1:0] t_prod, q_prod, qm_prod;
   logic [2*W-1:0] t2_ff, t3_ff, t4_ff, t5_ff;
   logic [2*W:0] add_in;
   logic [W-1:0] shi6_ff, out7_ff, out7_in;
   logic carry6_ff;
   logic in_acc, out_acc;

   // register port
   assign pready    = 1'b1;
   assign csr_index = paddr[3];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff     <= MODULUS_RESET;
         neg_inverse_ff <= NEG_INVERSE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MODULUS:     modulus_ff     <= pwdata;
            REG_NEG_INVERSE: neg_inverse_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MODULUS:     prdata = modulus_ff;
         REG_NEG_INVERSE: prdata = neg_inverse_ff;
         default:         prdata = '0;
      endcase
   end

   assign mod_w  = modulus_ff[W-1:0];
   assign ninv_w = neg_inverse_ff[W-1:0];

   // stage flow control: a stage loads when empty or when it moves on
   always_comb begin
      rdy[NUM_STAGES] = rsp_ready;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
   end

   assign valid_in  = {valid_ff[NUM_STAGES-2:0], req_valid};
   assign req_ready = rdy[0];
   assign in_acc    = req_valid && req_ready;
   assign out_acc   = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (rdy[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // t = a * b
   assign ab_en.pp_en  = rdy[ST_AB_PP];
   assign ab_en.sum_en = rdy[ST_AB_SUM];

   mmc_wide_mul #(.WORD_BITS(W)) u_mul_ab (
      .clock    (clock),
      .en       (ab_en),
      .mul_a    (req_operand_a[W-1:0]),
      .mul_b    (req_operand_b[W-1:0]),
      .mul_prod (t_prod)
   );

   // q = low(t) * neg_inverse, low word kept
   assign q_en.pp_en  = rdy[ST_Q_PP];
   assign q_en.sum_en = rdy[ST_Q_SUM];

   mmc_wide_mul #(.WORD_BITS(W)) u_mul_q (
      .clock    (clock),
      .en       (q_en),
      .mul_a    (t_prod[W-1:0]),
      .mul_b    (ninv_w),
      .mul_prod (q_prod)
   );

   // q * modulus
   assign qm_en.pp_en  = rdy[ST_QM_PP];
   assign qm_en.sum_en = rdy[ST_QM_SUM];

   mmc_wide_mul #(.WORD_BITS(W)) u_mul_qm (
      .clock    (clock),
      .en       (qm_en),
      .mul_a    (q_prod[W-1:0]),
      .mul_b    (mod_w),
      .mul_prod (qm_prod)
   );

   // t follows the q and q*m multipliers
   always_ff @(posedge clock) begin
      if (rdy[ST_Q_PP])   t2_ff <= t_prod;
      if (rdy[ST_Q_SUM])  t3_ff <= t2_ff;
      if (rdy[ST_QM_PP])  t4_ff <= t3_ff;
      if (rdy[ST_QM_SUM]) t5_ff <= t4_ff;
   end

   // double-width add, keep upper word and carry
   assign add_in = {1'b0, t5_ff} + {1'b0, qm_prod};

   always_ff @(posedge clock) begin
      if (rdy[ST_ADD]) begin
         carry6_ff <= add_in[2*W];
         shi6_ff   <= add_in[2*W-1:W];
      end
   end

   // single conditional subtraction of the modulus
   always_comb begin
      if (carry6_ff || (shi6_ff >= mod_w)) begin
         out7_in = shi6_ff - mod_w;
      end else begin
         out7_in = shi6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_REDUCE]) begin
         out7_ff <= out7_in;
      end
   end

   assign rsp_valid   = valid_ff[ST_REDUCE];
   assign rsp_product = 64'(out7_ff);

   // occupancy tracks accepted minus delivered transactions
   `MMC_ASSERT_NEXT(a_occupancy, clock, reset, !reset, $countones(valid_ff) == $past($countones(valid_ff)) + int'($past(in_acc)) - int'($past(out_acc)), "pipeline occupancy mismatch")

   // a full pipeline with a stalled output takes nothing new
   `MMC_ASSERT_SAME(a_full_stall, clock, reset, (&valid_ff) && !rsp_ready, !req_ready, "request taken into a full stalled pipeline")

   // an already reduced sum passes the last stage unchanged
   `MMC_ASSERT_NEXT(a_no_subtract, clock, reset, rdy[ST_REDUCE] && valid_ff[ST_ADD] && !carry6_ff && (shi6_ff < mod_w), out7_ff == $past(shi6_ff), "reduced sum altered")

endmodule

`default_nettype wire
